// File: rtl/core/ffra_pkg.sv
package ffra_pkg;

    localparam int MEM_UNITS      = 1024;
    localparam int RESERVED_UNITS = 64;
    localparam int MAX_BLOCKS     = 16;
    localparam int WORD_BITS      = 64;
    localparam int NUM_WORDS      = MEM_UNITS / WORD_BITS;
    localparam int UNIT_W         = $clog2(MEM_UNITS);
    localparam int SIZE_W         = UNIT_W + 1;
    localparam int WORD_IDX_W     = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W      = $clog2(WORD_BITS);
    localparam int ENTRY_W        = $clog2(MAX_BLOCKS);
    localparam int OWNER_W        = 8;
    localparam int STATUS_W       = 3;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd5;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_FETCH,
        S_LOAD,
        S_SCAN,
        S_MARK,
        S_DONE
    } state_t;

endpackage

// File: rtl/core/first_fit_region_allocator.sv
// A free of an unknown owner, a held block or a refused allocate goes from the lookup straight
// to its result word. Any other request takes a lookup step, a fetch and a load for each 64-unit
// bitmap word fetched, a step per unit scanned and one per unit marked or cleared, plus a closing
// step when no run fits, before its result word appears.
// The block handles one request at a time; the next word is taken only once the result has gone.
// Reset (aresetn low, synchronous) empties the block table and marks every bitmap word as free.
module first_fit_region_allocator
    import ffra_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [OWNER_W-1:0]  s_owner_id,
    input  logic [SIZE_W-1:0]   s_block_size,
    input  logic                s_realtime_req,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [UNIT_W-1:0]   m_start_index,
    output logic [UNIT_W-1:0]   m_last_index
);

    // Occupancy is held in a memory of 64-unit words with a registered read port. A word that
    // has never been written since reset reads as all free through its live bit.
    // The word under the unit pointer is copied into a working buffer, scanned or modified one
    // unit per cycle there. A modified word is written back when the pointer leaves it or marking ends.
    logic [WORD_BITS-1:0]  occ_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]  occ_live_reg;
    logic [WORD_BITS-1:0]  rd_word_reg;
    logic                  rd_live_reg;
    logic [WORD_BITS-1:0]  wbuf_reg, wbuf_next;
    logic [WORD_BITS-1:0]  wbuf_mod;
    logic [WORD_IDX_W-1:0] word_idx;
    logic [BIT_IDX_W-1:0]  bit_idx;
    logic                  rd_en;
    logic                  wr_en;

    logic [MAX_BLOCKS-1:0] ent_valid_reg;
    logic [OWNER_W-1:0]    ent_owner_reg  [MAX_BLOCKS];
    logic [UNIT_W-1:0]     ent_start_reg  [MAX_BLOCKS];
    logic [SIZE_W-1:0]     ent_length_reg [MAX_BLOCKS];

    state_t state_reg, state_next;

    // Latched request word.
    logic               kind_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               rt_reg;

    // Shared unit pointer, run counter and run start.
    logic [SIZE_W-1:0]  ptr_reg, ptr_next;
    logic [SIZE_W-1:0]  ptr_inc;
    logic [SIZE_W-1:0]  run_reg, run_next;
    logic [UNIT_W-1:0]  rstart_reg, rstart_next;
    logic [SIZE_W-1:0]  hi_reg, hi_next;
    logic [SIZE_W-1:0]  remain_reg, remain_next;
    logic               mark_val_reg, mark_val_next;
    logic               marking_reg, marking_next;
    logic [ENTRY_W-1:0] slot_reg, slot_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [UNIT_W-1:0]   first_reg, first_next;
    logic [UNIT_W-1:0]   last_reg, last_next;

    // Table updates: a new block claims its slot, a free drops the matching entry.
    logic claim;
    logic drop_hit;

    // Table lookups: priority encoders over the sixteen entries.
    logic               hit;
    logic [ENTRY_W-1:0] hit_idx;
    logic               has_free;
    logic [ENTRY_W-1:0] free_idx;

    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (ent_valid_reg[k] && ent_owner_reg[k] == owner_reg) begin
                hit = 1'b1;
                hit_idx = ENTRY_W'(k);
            end
            if (!ent_valid_reg[k]) begin
                has_free = 1'b1;
                free_idx = ENTRY_W'(k);
            end
        end
    end

    assign word_idx = ptr_reg[UNIT_W-1:BIT_IDX_W];
    assign bit_idx  = ptr_reg[BIT_IDX_W-1:0];
    assign ptr_inc  = ptr_reg + SIZE_W'(1);

    logic unit_busy;
    assign unit_busy = wbuf_reg[bit_idx];

    always_comb begin
        wbuf_mod = wbuf_reg;
        wbuf_mod[bit_idx] = mark_val_reg;
    end

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        run_next      = run_reg;
        rstart_next   = rstart_reg;
        hi_next       = hi_reg;
        remain_next   = remain_reg;
        mark_val_next = mark_val_reg;
        marking_next  = marking_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        wbuf_next     = wbuf_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        claim         = 1'b0;
        drop_hit      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                first_next = '0;
                last_next  = '0;
                state_next = S_DONE;
                if (kind_reg == KIND_FREE) begin
                    if (!hit) begin
                        status_next = ST_UNKNOWN;
                    end else begin
                        status_next   = ST_FREED;
                        first_next    = ent_start_reg[hit_idx];
                        last_next     = UNIT_W'(SIZE_W'(ent_start_reg[hit_idx])
                                        + ent_length_reg[hit_idx] - SIZE_W'(1));
                        ptr_next      = SIZE_W'(ent_start_reg[hit_idx]);
                        remain_next   = ent_length_reg[hit_idx];
                        mark_val_next = 1'b0;
                        marking_next  = 1'b1;
                        slot_next     = hit_idx;
                        drop_hit      = 1'b1;
                        state_next    = S_FETCH;
                    end
                end else if (hit) begin
                    status_next = ST_HELD;
                    first_next  = ent_start_reg[hit_idx];
                    last_next   = UNIT_W'(SIZE_W'(ent_start_reg[hit_idx])
                                  + ent_length_reg[hit_idx] - SIZE_W'(1));
                end else if (size_reg == '0) begin
                    status_next = ST_NO_SPACE;
                end else if (!has_free) begin
                    status_next = ST_TABLE_FULL;
                end else begin
                    slot_next    = free_idx;
                    ptr_next     = rt_reg ? '0 : SIZE_W'(RESERVED_UNITS);
                    rstart_next  = rt_reg ? '0 : UNIT_W'(RESERVED_UNITS);
                    hi_next      = rt_reg ? SIZE_W'(RESERVED_UNITS) : SIZE_W'(MEM_UNITS);
                    run_next     = '0;
                    marking_next = 1'b0;
                    status_next  = ST_NO_SPACE;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH: begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                wbuf_next  = rd_live_reg ? rd_word_reg : '0;
                state_next = marking_reg ? S_MARK : S_SCAN;
            end
            S_SCAN: begin
                if (ptr_reg >= hi_reg) begin
                    state_next = S_DONE;
                end else if (!unit_busy && run_reg + SIZE_W'(1) >= size_reg) begin
                    // The run is long enough: go back to its first word and mark it.
                    status_next   = ST_ALLOCATED;
                    first_next    = rstart_reg;
                    last_next     = UNIT_W'(SIZE_W'(rstart_reg) + size_reg - SIZE_W'(1));
                    ptr_next      = SIZE_W'(rstart_reg);
                    remain_next   = size_reg;
                    mark_val_next = 1'b1;
                    marking_next  = 1'b1;
                    claim         = 1'b1;
                    state_next    = S_FETCH;
                end else begin
                    if (unit_busy) begin
                        run_next    = '0;
                        rstart_next = UNIT_W'(ptr_inc);
                    end else begin
                        run_next = run_reg + SIZE_W'(1);
                    end
                    ptr_next = ptr_inc;
                    if (ptr_inc[BIT_IDX_W-1:0] == '0 && ptr_inc < hi_reg) begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_MARK: begin
                wbuf_next   = wbuf_mod;
                ptr_next    = ptr_inc;
                remain_next = remain_reg - SIZE_W'(1);
                if (remain_reg == SIZE_W'(1)) begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end else if (bit_idx == BIT_IDX_W'(WORD_BITS - 1)) begin
                    wr_en      = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            occ_mem[word_idx] <= wbuf_mod;
        end
        if (rd_en) begin
            rd_word_reg <= occ_mem[word_idx];
            rd_live_reg <= occ_live_reg[word_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_live_reg  <= '0;
            ent_valid_reg <= '0;
        end else begin
            if (wr_en) begin
                occ_live_reg[word_idx] <= 1'b1;
            end
            if (claim) begin
                ent_valid_reg[slot_reg] <= 1'b1;
            end
            if (drop_hit) begin
                ent_valid_reg[hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (claim) begin
            ent_owner_reg[slot_reg]  <= owner_reg;
            ent_start_reg[slot_reg]  <= rstart_reg;
            ent_length_reg[slot_reg] <= size_reg;
        end
        if (state_reg == S_IDLE && s_valid) begin
            kind_reg  <= s_kind;
            owner_reg <= s_owner_id;
            size_reg  <= s_block_size;
            rt_reg    <= s_realtime_req;
        end
        ptr_reg      <= ptr_next;
        run_reg      <= run_next;
        rstart_reg   <= rstart_next;
        hi_reg       <= hi_next;
        remain_reg   <= remain_next;
        mark_val_reg <= mark_val_next;
        marking_reg  <= marking_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        wbuf_reg     <= wbuf_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_DONE);
    assign m_status      = status_reg;
    assign m_start_index = first_reg;
    assign m_last_index  = last_reg;

`ifndef NO_ASSERTIONS
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and result sides both open");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> ptr_reg <= hi_reg)
        else $error("scan pointer past region end");
    a_write_in_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == S_MARK)
        else $error("bitmap written outside mark phase");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

// Checks the first-fit region allocator. The testbench carries its own model of the
// occupancy bitmap and the block table. Every request word is run through that model
// when the allocator accepts it, and every result word is compared with the oldest
// outstanding prediction.
module testbench;
    import ffra_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [UNIT_W-1:0]   first;
        logic [UNIT_W-1:0]   last;
    } alloc_result_t;

    typedef struct {
        logic                kind;
        logic [OWNER_W-1:0]  owner;
        logic [SIZE_W-1:0]   size;
        logic                rt;
        bit                  has_fixed;
        alloc_result_t       fixed;
    } request_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = KIND_ALLOC;
    logic [OWNER_W-1:0] s_owner_id = '0;
    logic [SIZE_W-1:0] s_block_size = '0;
    logic s_realtime_req = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [UNIT_W-1:0] m_start_index;
    logic [UNIT_W-1:0] m_last_index;

    first_fit_region_allocator uut (.*);

    always #10 aclk = ~aclk;

    // This is the predictor's copy of the allocator state.
    bit                 unit_busy [MEM_UNITS];
    bit                 blk_valid [MAX_BLOCKS];
    logic [OWNER_W-1:0] blk_owner [MAX_BLOCKS];
    int                 blk_start [MAX_BLOCKS];
    int                 blk_len   [MAX_BLOCKS];

    alloc_result_t pending_results [$];
    int errors = 0;
    int results_seen = 0;
    int cycles_idle = 0;
    int rx_gap = 0;
    bit quiet_tail = 0;
    bit rx_hold = 0;
    int stat_count [6];

    // The predictor handles one request and returns the word that the allocator should send.
    function automatic alloc_result_t predict_allocation(logic kind, logic [OWNER_W-1:0] owner,
                                                         logic [SIZE_W-1:0] size, logic rt);
        alloc_result_t r;
        int hit;
        int slot;
        int lo;
        int hi;
        int run;
        int run_at;
        int found;
        r = '0;
        hit = -1;
        slot = -1;
        found = -1;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (blk_valid[k] && blk_owner[k] == owner) hit = k;
            if (!blk_valid[k]) slot = k;
        end
        if (kind == KIND_FREE) begin
            if (hit < 0) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            for (int i = 0; i < blk_len[hit]; i++) unit_busy[blk_start[hit] + i] = 0;
            blk_valid[hit] = 0;
            r.status = ST_FREED;
            r.first = UNIT_W'(blk_start[hit]);
            r.last = UNIT_W'(blk_start[hit] + blk_len[hit] - 1);
            return r;
        end
        if (hit >= 0) begin
            r.status = ST_HELD;
            r.first = UNIT_W'(blk_start[hit]);
            r.last = UNIT_W'(blk_start[hit] + blk_len[hit] - 1);
            return r;
        end
        if (size == 0) begin
            r.status = ST_NO_SPACE;
            return r;
        end
        if (slot < 0) begin
            r.status = ST_TABLE_FULL;
            return r;
        end
        lo = rt ? 0 : RESERVED_UNITS;
        hi = rt ? RESERVED_UNITS : MEM_UNITS;
        run = 0;
        run_at = lo;
        for (int i = lo; i < hi && found < 0; i++) begin
            if (unit_busy[i]) begin
                run = 0;
                run_at = i + 1;
            end else begin
                run++;
                if (run >= size) found = run_at;
            end
        end
        if (found < 0) begin
            r.status = ST_NO_SPACE;
            return r;
        end
        for (int i = 0; i < size; i++) unit_busy[found + i] = 1;
        blk_valid[slot] = 1;
        blk_owner[slot] = owner;
        blk_start[slot] = found;
        blk_len[slot] = int'(size);
        r.status = ST_ALLOCATED;
        r.first = UNIT_W'(found);
        r.last = UNIT_W'(found + int'(size) - 1);
        return r;
    endfunction

    // The sender holds a word until it is accepted, with optional random gaps before it.
    task automatic send_request(request_row_t row, bit allow_gaps);
        alloc_result_t exp;
        if (allow_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= row.kind;
        s_owner_id <= row.owner;
        s_block_size <= row.size;
        s_realtime_req <= row.rt;
        do @(posedge aclk); while (!s_ready);
        exp = predict_allocation(row.kind, row.owner, row.size, row.rt);
        if (row.has_fixed && exp !== row.fixed) begin
            $error("table row disagrees with predictor: row %h predicted %h", row.fixed, exp);
            errors++;
        end
        pending_results.push_back(exp);
    endtask

    function automatic request_row_t make_row(logic kind, int owner, int size, logic rt);
        request_row_t row;
        row.kind = kind;
        row.owner = OWNER_W'(owner);
        row.size = SIZE_W'(size);
        row.rt = rt;
        row.has_fixed = 0;
        row.fixed = '0;
        return row;
    endfunction

    function automatic request_row_t fixed_row(logic kind, int owner, int size, logic rt,
                                               logic [STATUS_W-1:0] st, int first, int last);
        request_row_t row;
        row = make_row(kind, owner, size, rt);
        row.has_fixed = 1;
        row.fixed.status = st;
        row.fixed.first = UNIT_W'(first);
        row.fixed.last = UNIT_W'(last);
        return row;
    endfunction

    // The receiver stalls in random bursts. One long hold-off lets the input back up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (quiet_tail) begin
            m_ready <= 1'b1;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            rx_gap <= $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // The checker compares each result word with the oldest prediction.
    always @(posedge aclk) begin
        alloc_result_t exp;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with no request outstanding: status %0d", m_status);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (m_status < 6) stat_count[m_status]++;
                if (m_status !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, m_status);
                    errors++;
                end
                if (m_start_index !== exp.first) begin
                    $error("start_index: expected %0d, got %0d", exp.first, m_start_index);
                    errors++;
                end
                if (m_last_index !== exp.last) begin
                    $error("last_index: expected %0d, got %0d", exp.last, m_last_index);
                    errors++;
                end
            end
        end
    end

    // The watchdog allows for the slowest request: a full scan plus marking,
    // together with the longest stalls on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            cycles_idle <= 0;
        end else begin
            cycles_idle <= cycles_idle + 1;
        end
        if (cycles_idle > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The long receiver hold-off is counted in a process of its own.
    initial begin
        wait (aresetn);
        repeat (3000) @(posedge aclk);
        rx_hold <= 1;
        repeat (400) @(posedge aclk);
        rx_hold <= 0;
    end

    initial begin
        request_row_t directed [$];
        request_row_t row;
        int owner_pool;
        int pick;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_valid[i] = 0;
        end
        for (int i = 0; i < MEM_UNITS; i++) begin
            unit_busy[i] = 0;
        end

        // Directed words: extremes, each status, and region edges.
        directed.push_back(fixed_row(KIND_FREE, 0, 0, 0, ST_UNKNOWN, 0, 0));
        directed.push_back(fixed_row(KIND_ALLOC, 1, 0, 0, ST_NO_SPACE, 0, 0));
        directed.push_back(fixed_row(KIND_ALLOC, 2, 1024, 0, ST_NO_SPACE, 0, 0));
        directed.push_back(fixed_row(KIND_ALLOC, 3, 65, 1, ST_NO_SPACE, 0, 0));
        directed.push_back(fixed_row(KIND_ALLOC, 4, 64, 1, ST_ALLOCATED, 0, 63));
        directed.push_back(fixed_row(KIND_ALLOC, 255, 960, 0, ST_ALLOCATED, 64, 1023));
        directed.push_back(fixed_row(KIND_ALLOC, 255, 5, 1, ST_HELD, 64, 1023));
        directed.push_back(fixed_row(KIND_ALLOC, 6, 1, 0, ST_NO_SPACE, 0, 0));
        directed.push_back(fixed_row(KIND_FREE, 255, 2047, 1, ST_FREED, 64, 1023));
        directed.push_back(fixed_row(KIND_FREE, 4, 0, 0, ST_FREED, 0, 63));
        directed.push_back(fixed_row(KIND_FREE, 4, 0, 0, ST_UNKNOWN, 0, 0));
        directed.push_back(fixed_row(KIND_ALLOC, 7, 2047, 1, ST_NO_SPACE, 0, 0));
        // Sixteen small blocks, sized so that the reserved ones all fit, fill the table.
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            directed.push_back(make_row(KIND_ALLOC, 10 + i, 1 + i[2:0], i[0]));
        end
        directed.push_back(fixed_row(KIND_ALLOC, 200, 1, 0, ST_TABLE_FULL, 0, 0));
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            directed.push_back(make_row(KIND_FREE, 10 + i, 0, 0));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_request(directed[i], 1);

        // The random words come mostly from a small pool of owners, so that the
        // table fills and empties. A few use wide sizes and arbitrary owners.
        for (int n = 0; n < 2000; n++) begin
            if (n > 1800) quiet_tail = 1;
            owner_pool = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 23);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                row = make_row(KIND_ALLOC, owner_pool, $urandom_range(1, 64),
                               $urandom_range(0, 3) == 0);
            end else if (pick < 58) begin
                row = make_row(KIND_ALLOC, owner_pool, $urandom_range(0, 2047),
                               1'($urandom_range(0, 1)));
            end else begin
                row = make_row(KIND_FREE, owner_pool, $urandom_range(0, 2047),
                               1'($urandom_range(0, 1)));
            end
            send_request(row, 1);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Covered %0d results: allocated %0d, held %0d, no space %0d,", results_seen,
                 stat_count[0], stat_count[1], stat_count[2]);
        $display("table full %0d, freed %0d, unknown owner %0d.", stat_count[3],
                 stat_count[4], stat_count[5]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
